/* rtl/nta_pkg.sv */
// shared types, codes and helper functions for the number to ascii formatter
package nta_pkg;

    // format kind codes carried on tuser
    localparam logic [1:0] KIND_DEC_BYTE = 2'd0;
    localparam logic [1:0] KIND_DEC_WORD = 2'd1;
    localparam logic [1:0] KIND_HEX_BYTE = 2'd2;
    localparam logic [1:0] KIND_BIN_BYTE = 2'd3;

    // character constants
    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [3:0] HEX_TEN       = 4'd10;

    // run geometry
    localparam int NUM_CHARS          = 8;
    localparam int NUM_DD             = 4;
    localparam int DD_STEPS_PER_STAGE = 4;
    localparam int BCD_DIGITS         = 5;

    // last character index per kind
    localparam logic [2:0] LAST_DEC_BYTE = 3'd2;
    localparam logic [2:0] LAST_DEC_WORD = 3'd4;
    localparam logic [2:0] LAST_HEX_BYTE = 3'd1;
    localparam logic [2:0] LAST_BIN_BYTE = 3'd7;

    // item as it moves through the double-dabble stages
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  lo_byte;
        logic [19:0] bcd;
        logic [15:0] bin;
    } dd_t;

    // item ready for the serializer
    typedef struct packed {
        logic [NUM_CHARS-1:0][6:0] chars;
        logic [2:0]                last_idx;
    } fmt_t;

    // one shift-and-add-3 step of binary to bcd conversion
    function automatic dd_t dd_step(dd_t d);
        dd_t         r;
        logic [19:0] b;
        r = d;
        b = d.bcd;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (b[4*k +: 4] >= 4'd5) begin
                b[4*k +: 4] = b[4*k +: 4] + 4'd3;
            end
        end
        r.bcd = {b[18:0], d.bin[15]};
        r.bin = {d.bin[14:0], 1'b0};
        return r;
    endfunction

    // uppercase hex digit of a nibble
    function automatic logic [6:0] hex_char(logic [3:0] nib);
        logic [6:0] c;
        if (nib < HEX_TEN) begin
            c = ASCII_ZERO + {3'b000, nib};
        end
        else begin
            c = ASCII_UPPER_A + {3'b000, nib} - {3'b000, HEX_TEN};
        end
        return c;
    endfunction

    // decimal digit character
    function automatic logic [6:0] dec_char(logic [3:0] dig);
        return ASCII_ZERO + {3'b000, dig};
    endfunction

endpackage

/* rtl/nta_dd_stage.sv */
// one pipeline stage of the binary to bcd converter, four dabble steps
module nta_dd_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nta_pkg::dd_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output nta_pkg::dd_t  out_data
);
    import nta_pkg::*;

    logic vld_reg;
    logic vld_next;
    dd_t  data_reg;
    dd_t  data_next;

    // stage takes a new transfer when empty or when its content moves on
    assign in_ready = !vld_reg || out_ready;

    // dabble steps for this stage
    always_comb
    begin
        data_next = in_data;
        for (int s = 0; s < DD_STEPS_PER_STAGE; s++) begin
            data_next = dd_step(data_next);
        end
    end

    assign vld_next = in_ready ? in_valid : vld_reg;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/nta_fmt.sv */
// character build stage: turns bcd digits or the raw byte into ascii codes
module nta_fmt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nta_pkg::dd_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output nta_pkg::fmt_t out_data
);
    import nta_pkg::*;

    logic vld_reg;
    logic vld_next;
    fmt_t data_reg;
    fmt_t data_next;

    assign in_ready = !vld_reg || out_ready;

    // pick characters by kind, unused slots are zero
    always_comb
    begin
        data_next = '0;
        case (in_data.kind)
            KIND_DEC_BYTE:
            begin
                data_next.chars[0] = dec_char(in_data.bcd[11:8]);
                data_next.chars[1] = dec_char(in_data.bcd[7:4]);
                data_next.chars[2] = dec_char(in_data.bcd[3:0]);
                data_next.last_idx = LAST_DEC_BYTE;
            end
            KIND_DEC_WORD:
            begin
                data_next.chars[0] = dec_char(in_data.bcd[19:16]);
                data_next.chars[1] = dec_char(in_data.bcd[15:12]);
                data_next.chars[2] = dec_char(in_data.bcd[11:8]);
                data_next.chars[3] = dec_char(in_data.bcd[7:4]);
                data_next.chars[4] = dec_char(in_data.bcd[3:0]);
                data_next.last_idx = LAST_DEC_WORD;
            end
            KIND_HEX_BYTE:
            begin
                data_next.chars[0] = hex_char(in_data.lo_byte[7:4]);
                data_next.chars[1] = hex_char(in_data.lo_byte[3:0]);
                data_next.last_idx = LAST_HEX_BYTE;
            end
            KIND_BIN_BYTE:
            begin
                for (int n = 0; n < NUM_CHARS; n++) begin
                    data_next.chars[n] = ASCII_ZERO + {6'b000000, in_data.lo_byte[7-n]};
                end
                data_next.last_idx = LAST_BIN_BYTE;
            end
            default:
            begin
                data_next = '0;
            end
        endcase
    end

    assign vld_next = in_ready ? in_valid : vld_reg;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/nta_ser.sv */
// output serializer: sends one character per transfer and flags the last one
module nta_ser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nta_pkg::fmt_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [6:0]    out_char,
    output logic          out_last
);
    import nta_pkg::*;

    logic       vld_reg;
    logic       vld_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    fmt_t       item_reg;
    logic       take;
    logic       load;

    assign out_last  = vld_reg && (idx_reg == item_reg.last_idx);
    assign out_valid = vld_reg;
    assign out_char  = item_reg.chars[idx_reg];

    // next item loads while the last character of the current one leaves
    assign take     = vld_reg && out_ready;
    assign in_ready = !vld_reg || (out_ready && out_last);
    assign load     = in_valid && in_ready;

    // index and valid update
    always_comb
    begin
        vld_next = vld_reg;
        idx_next = idx_reg;
        if (load) begin
            vld_next = 1'b1;
            idx_next = '0;
        end
        else if (take) begin
            if (out_last) begin
                vld_next = 1'b0;
                idx_next = '0;
            end
            else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else begin
            vld_reg <= vld_next;
            idx_reg <= idx_next;
        end
    end

    // held item
    always_ff @(posedge clk)
    begin
        if (load) begin
            item_reg <= in_data;
        end
    end

endmodule

/* rtl/number_to_ascii_formatter.sv */
// top level of the number to ascii formatter: bcd pipeline, formatter, serializer
// Formats a number as ASCII digits, one character per output transfer with
// tlast on the final one: kind 0 gives three decimal digits of the low byte,
// kind 1 five decimal digits of the 16-bit word, kind 2 two uppercase hex
// digits of the low byte, kind 3 eight binary digits of the low byte, msb
// first. Leading zeros are always sent. An input transfer enters a four-stage
// double-dabble pipeline, then a character build stage, then the serializer,
// each stage registered. The pipeline takes one input per cycle until it fills;
// sustained throughput is set by the serializer, which sends one character per
// cycle while the output is ready.
module number_to_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] character, [7] zero
    output logic        m_axis_tlast
);
    import nta_pkg::*;

    dd_t               dd_in;
    dd_t               dd_data [NUM_DD+1];
    logic [NUM_DD:0]   dd_valid;
    logic [NUM_DD:0]   dd_ready;
    fmt_t              fmt_data;
    logic              fmt_valid;
    logic              fmt_ready;
    logic [6:0]        out_char;

    // conversion input: byte kinds use the low byte only
    always_comb
    begin
        dd_in.kind    = s_axis_tuser;
        dd_in.lo_byte = s_axis_tdata[7:0];
        dd_in.bcd     = '0;
        if (s_axis_tuser == KIND_DEC_WORD) begin
            dd_in.bin = s_axis_tdata;
        end
        else begin
            dd_in.bin = {8'h00, s_axis_tdata[7:0]};
        end
    end

    assign dd_data[0]    = dd_in;
    assign dd_valid[0]   = s_axis_tvalid;
    assign s_axis_tready = dd_ready[0];

    // binary to bcd pipeline
    for (genvar g = 0; g < NUM_DD; g++) begin : g_dd
        nta_dd_stage u_dd (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dd_valid[g]),
            .in_ready  (dd_ready[g]),
            .in_data   (dd_data[g]),
            .out_valid (dd_valid[g+1]),
            .out_ready (dd_ready[g+1]),
            .out_data  (dd_data[g+1])
        );
    end

    // character build
    nta_fmt u_fmt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dd_valid[NUM_DD]),
        .in_ready  (dd_ready[NUM_DD]),
        .in_data   (dd_data[NUM_DD]),
        .out_valid (fmt_valid),
        .out_ready (fmt_ready),
        .out_data  (fmt_data)
    );

    // serializer and output
    nta_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fmt_valid),
        .in_ready  (fmt_ready),
        .in_data   (fmt_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

/* test/number_to_ascii_formatter_tb.sv */
// self-checking testbench for the number to ascii formatter stream block
module number_to_ascii_formatter_tb;

    import nta_pkg::*;

    localparam int RANDOM_ITEMS = 208;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 200;

    // one expected output character
    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } char_t;

    // directed stimulus row; text_len of zero means the digits come from the predictor
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [3:0]  text_len;
        logic [63:0] text;
    } row_t;

    localparam int NUM_ROWS = 22;
    localparam row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        '{KIND_DEC_BYTE, 16'h0000, 4'd3, "000"},
        '{KIND_DEC_BYTE, 16'h00FF, 4'd3, "255"},
        '{KIND_DEC_BYTE, 16'hFF00, 4'd3, "000"},
        '{KIND_DEC_BYTE, 16'hFFFF, 4'd3, "255"},
        '{KIND_DEC_BYTE, 16'h1234, 4'd0, 64'd0},
        '{KIND_DEC_BYTE, 16'h0009, 4'd3, "009"},
        '{KIND_DEC_BYTE, 16'd100,  4'd0, 64'd0},
        '{KIND_DEC_WORD, 16'h0000, 4'd5, "00000"},
        '{KIND_DEC_WORD, 16'hFFFF, 4'd5, "65535"},
        '{KIND_DEC_WORD, 16'd60000, 4'd5, "60000"},
        '{KIND_DEC_WORD, 16'd9999, 4'd0, 64'd0},
        '{KIND_DEC_WORD, 16'd12345, 4'd0, 64'd0},
        '{KIND_DEC_WORD, 16'd10000, 4'd0, 64'd0},
        '{KIND_HEX_BYTE, 16'h0000, 4'd2, "00"},
        '{KIND_HEX_BYTE, 16'h00FF, 4'd2, "FF"},
        '{KIND_HEX_BYTE, 16'hABA9, 4'd0, 64'd0},
        '{KIND_HEX_BYTE, 16'h000A, 4'd0, 64'd0},
        '{KIND_BIN_BYTE, 16'h0000, 4'd8, "00000000"},
        '{KIND_BIN_BYTE, 16'h00FF, 4'd8, "11111111"},
        '{KIND_BIN_BYTE, 16'hFF80, 4'd8, "10000000"},
        '{KIND_BIN_BYTE, 16'h0001, 4'd8, "00000001"},
        '{KIND_BIN_BYTE, 16'h00A5, 4'd0, 64'd0}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [15:0] value
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [6:0] character, [7] zero
    logic        m_axis_tlast;

    char_t pending_chars[$];
    int    err_count   = 0;
    int    cycle_count = 0;
    int    recv_count  = 0;
    bit    rx_holding  = 1'b0;

    number_to_ascii_formatter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #5 clk = ~clk;

    // queue one expected character
    function automatic void push_char(logic [6:0] code, logic last);
        char_t c;
        c.code = code;
        c.last = last;
        pending_chars.push_back(c);
    endfunction

    // uppercase hex character of a nibble
    function automatic logic [6:0] nibble_char(logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10)
        begin
            c = ASCII_ZERO + 7'(nib);
        end
        else
        begin
            c = ASCII_UPPER_A + 7'(nib) - 7'd10;
        end
        return c;
    endfunction

    // work out the digit run of one item and queue it
    function automatic void predict_digits(logic [1:0] kind, logic [15:0] value);
        int unsigned w;
        int unsigned b;
        w = 32'(value);
        b = 32'(value[7:0]);
        case (kind)
            KIND_DEC_BYTE:
            begin
                push_char(ASCII_ZERO + 7'(b / 100), 1'b0);
                push_char(ASCII_ZERO + 7'((b / 10) % 10), 1'b0);
                push_char(ASCII_ZERO + 7'(b % 10), 1'b1);
            end
            KIND_DEC_WORD:
            begin
                push_char(ASCII_ZERO + 7'(w / 10000), 1'b0);
                push_char(ASCII_ZERO + 7'((w / 1000) % 10), 1'b0);
                push_char(ASCII_ZERO + 7'((w / 100) % 10), 1'b0);
                push_char(ASCII_ZERO + 7'((w / 10) % 10), 1'b0);
                push_char(ASCII_ZERO + 7'(w % 10), 1'b1);
            end
            KIND_HEX_BYTE:
            begin
                push_char(nibble_char(value[7:4]), 1'b0);
                push_char(nibble_char(value[3:0]), 1'b1);
            end
            default:
            begin
                // msb first
                for (int n = 0; n < 8; n++)
                begin
                    push_char(ASCII_ZERO + 7'(value[7-n]), n == 7);
                end
            end
        endcase
    endfunction

    // offer one item after a random gap (none when quiet or while the receiver holds off) and wait for its transfer
    task automatic send_item(logic [1:0] kind, logic [15:0] value, bit quiet);
        int gap;
        gap = (quiet || rx_holding) ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("number_to_ascii_formatter_tb: done, errors");
        $finish;
    end

    // output side: random stalls, one long hold-off, and checking
    initial
    begin
        int  stall;
        bit  hold_done;
        char_t want;
        hold_done = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = ((recv_count / 100) % 2 == 1) ? 0 : $urandom_range(0, 4);
            if (!hold_done && recv_count >= HOLD_AFTER)
            begin
                stall      = HOLD_CYCLES;
                hold_done  = 1'b1;
                rx_holding = 1'b1;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rx_holding     = 1'b0;
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            recv_count++;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected transfer: character %h last %b",
                       m_axis_tdata[6:0], m_axis_tlast);
                err_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_axis_tdata[6:0] !== want.code)
                begin
                    $error("character: expected %h actual %h", want.code, m_axis_tdata[6:0]);
                    err_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %b actual %b", want.last, m_axis_tlast);
                    err_count++;
                end
                if (m_axis_tdata[7] !== 1'b0)
                begin
                    $error("pad: expected 0 actual %b", m_axis_tdata[7]);
                    err_count++;
                end
            end
        end
    end

    // reset, input side stimulus and end of run
    initial
    begin
        row_t        r;
        logic [1:0]  kind;
        logic [15:0] value;
        int          sel;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            r = DIRECTED_ROWS[i];
            send_item(r.kind, r.value, 1'b0);
            if (r.text_len == 0)
            begin
                predict_digits(r.kind, r.value);
            end
            else
            begin
                for (int k = 0; k < r.text_len; k++)
                begin
                    push_char(r.text[8*(r.text_len-1-k) +: 7], k == r.text_len - 1);
                end
            end
        end

        // random items, with extremes mixed in
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = 2'($urandom_range(0, 3));
            sel  = $urandom_range(0, 9);
            case (sel)
                0:       value = 16'h0000;
                1:       value = 16'hFFFF;
                2:       value = 16'($urandom_range(0, 255));
                default: value = 16'($urandom);
            endcase
            send_item(kind, value, (i / 40) % 2 == 1);
            predict_digits(kind, value);
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && pending_chars.size() == 0)
        begin
            $display("number_to_ascii_formatter_tb: done, clean");
        end
        else
        begin
            $display("number_to_ascii_formatter_tb: done, errors");
        end
        $finish;
    end

endmodule

/* number_to_ascii_formatter.f */
rtl/nta_pkg.sv
rtl/nta_dd_stage.sv
rtl/nta_fmt.sv
rtl/nta_ser.sv
rtl/number_to_ascii_formatter.sv
test/number_to_ascii_formatter_tb.sv
